// ----- rtl/rsa_pkg.sv -----
// Shared types, constants and microcode program of the rational sum accumulator.
package rsa_pkg;

    localparam int FRAC_W = 32;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_DEN = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        U_NOP,
        U_LOAD,
        U_PREP,
        U_MUL,
        U_COMB,
        U_G_TWO,
        U_G_AODD,
        U_G_BODD,
        U_G_SUB,
        U_G_SCALE,
        U_DIV_INIT,
        U_DIV,
        U_CHECK,
        U_ZERO,
        U_OUT
    } t_uop;

    typedef enum logic [3:0] {
        C_NONE,
        C_ALWAYS,
        C_NO_IN,
        C_SKIP,
        C_CNT,
        C_NUM_ZERO,
        C_BOTH_EVEN,
        C_A_EVEN,
        C_B_EVEN,
        C_A_NE_B,
        C_K_NZ,
        C_OUT_BUSY
    } t_cond;

    typedef logic [3:0] t_pc;

    localparam t_pc PC_IDLE     = 4'd0;
    localparam t_pc PC_PREP     = 4'd1;
    localparam t_pc PC_MUL      = 4'd2;
    localparam t_pc PC_COMB     = 4'd3;
    localparam t_pc PC_G_TWO    = 4'd4;
    localparam t_pc PC_G_AODD   = 4'd5;
    localparam t_pc PC_G_BODD   = 4'd6;
    localparam t_pc PC_G_SUB    = 4'd7;
    localparam t_pc PC_G_SCALE  = 4'd8;
    localparam t_pc PC_DIV_INIT = 4'd9;
    localparam t_pc PC_DIV      = 4'd10;
    localparam t_pc PC_CHECK    = 4'd11;
    localparam t_pc PC_ZERO     = 4'd12;
    localparam t_pc PC_OUT      = 4'd13;
    localparam t_pc PC_WRAP     = 4'd14;

    typedef struct packed {
        t_uop  uop;
        t_cond cond;
        t_pc   target;
    } t_cw;

    typedef struct packed {
        logic in_valid;
        logic skip;
        logic cnt_nz;
        logic num_zero;
        logic both_even;
        logic a_even;
        logic b_even;
        logic a_ne_b;
        logic k_nz;
        logic out_busy;
    } t_flags;

    function automatic t_cw ucode(input t_pc pc);
        t_cw cw;
        case (pc)
            PC_IDLE:     cw = '{U_LOAD,     C_NO_IN,     PC_IDLE};
            PC_PREP:     cw = '{U_PREP,     C_SKIP,      PC_OUT};
            PC_MUL:      cw = '{U_MUL,      C_CNT,       PC_MUL};
            PC_COMB:     cw = '{U_COMB,     C_NUM_ZERO,  PC_ZERO};
            PC_G_TWO:    cw = '{U_G_TWO,    C_BOTH_EVEN, PC_G_TWO};
            PC_G_AODD:   cw = '{U_G_AODD,   C_A_EVEN,    PC_G_AODD};
            PC_G_BODD:   cw = '{U_G_BODD,   C_B_EVEN,    PC_G_BODD};
            PC_G_SUB:    cw = '{U_G_SUB,    C_A_NE_B,    PC_G_BODD};
            PC_G_SCALE:  cw = '{U_G_SCALE,  C_K_NZ,      PC_G_SCALE};
            PC_DIV_INIT: cw = '{U_DIV_INIT, C_NONE,      PC_IDLE};
            PC_DIV:      cw = '{U_DIV,      C_CNT,       PC_DIV};
            PC_CHECK:    cw = '{U_CHECK,    C_ALWAYS,    PC_OUT};
            PC_ZERO:     cw = '{U_ZERO,     C_NONE,      PC_IDLE};
            PC_OUT:      cw = '{U_OUT,      C_OUT_BUSY,  PC_OUT};
            PC_WRAP:     cw = '{U_NOP,      C_ALWAYS,    PC_IDLE};
            default:     cw = '{U_NOP,      C_ALWAYS,    PC_IDLE};
        endcase
        return cw;
    endfunction

endpackage

// ----- rtl/rsa_seq.sv -----
// Microcode sequencer: step counter, program lookup and conditional jumps.
module rsa_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rsa_pkg::t_flags i_flags,
    output rsa_pkg::t_cw    o_cw
);

    rsa_pkg::t_pc r_pc;
    rsa_pkg::t_pc n_pc;
    rsa_pkg::t_cw cw;
    logic         take;

    always_comb begin
        cw = rsa_pkg::ucode(r_pc);
        case (cw.cond)
            rsa_pkg::C_NONE:      take = 1'b0;
            rsa_pkg::C_ALWAYS:    take = 1'b1;
            rsa_pkg::C_NO_IN:     take = !i_flags.in_valid;
            rsa_pkg::C_SKIP:      take = i_flags.skip;
            rsa_pkg::C_CNT:       take = i_flags.cnt_nz;
            rsa_pkg::C_NUM_ZERO:  take = i_flags.num_zero;
            rsa_pkg::C_BOTH_EVEN: take = i_flags.both_even;
            rsa_pkg::C_A_EVEN:    take = i_flags.a_even;
            rsa_pkg::C_B_EVEN:    take = i_flags.b_even;
            rsa_pkg::C_A_NE_B:    take = i_flags.a_ne_b;
            rsa_pkg::C_K_NZ:      take = i_flags.k_nz;
            rsa_pkg::C_OUT_BUSY:  take = i_flags.out_busy;
            default:              take = 1'b1;
        endcase
        n_pc = take ? cw.target : rsa_pkg::t_pc'(r_pc + 4'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= rsa_pkg::PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_cw = cw;

endmodule

// ----- rtl/rsa_dp.sv -----
// Datapath: sum state, shift-add multiplier, binary gcd, dual restoring divider.
module rsa_dp #(
    parameter int W = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  rsa_pkg::t_cw                      i_cw,
    input  logic                              i_in_valid,
    input  logic signed [rsa_pkg::FRAC_W-1:0] i_frac_num,
    input  logic signed [rsa_pkg::FRAC_W-1:0] i_frac_den,
    input  logic                              i_restart,
    input  logic                              i_out_stall,
    output rsa_pkg::t_flags                   o_flags,
    output logic                              o_out_valid,
    output logic signed [W-1:0]               o_sum_num,
    output logic [W-2:0]                      o_sum_den,
    output logic [1:0]                        o_sum_status
);

    localparam int FW = rsa_pkg::FRAC_W;
    localparam int PW = W + FW;
    localparam int CW = $clog2(PW);

    logic [FW-1:0]      r_n, n_n, r_d, n_d;
    logic               r_restart, n_restart;
    logic [W-1:0]       r_acc_num, n_acc_num;
    logic [W-2:0]       r_acc_den, n_acc_den;
    rsa_pkg::t_status   r_acc_status, n_acc_status;
    logic [PW-1:0]      r_ma, n_ma, r_mb, n_mb;
    logic [PW-1:0]      r_p1, n_p1, r_p2, n_p2, r_p3, n_p3;
    logic [PW-1:0]      r_rem1, n_rem1, r_rem2, n_rem2;
    logic [CW-1:0]      r_cnt, n_cnt, r_k, n_k;
    logic               r_a_neg, n_a_neg, r_t2_neg, n_t2_neg, r_s_neg, n_s_neg;
    logic               r_o_valid, n_o_valid;
    logic [W-1:0]       r_o_num, n_o_num;
    logic [W-2:0]       r_o_den, n_o_den;
    rsa_pkg::t_status   r_o_status, n_o_status;

    rsa_pkg::t_status   st_e;
    logic [W-1:0]       num_e, a_mag;
    logic [W-2:0]       den_e;
    logic [FW-1:0]      n_mag, d_mag;
    logic [PW-1:0]      sum_t, numc, big, lesser;
    logic [PW:0]        diff_t;
    logic               sneg_c, a_gt, out_busy;
    logic [PW:0]        sh1, sh2;
    logic               ge1, ge2, den_fit, num_fit;

    always_comb begin
        st_e  = r_restart ? rsa_pkg::ST_OK : r_acc_status;
        num_e = r_restart ? '0 : r_acc_num;
        den_e = r_restart ? (W-1)'(1) : r_acc_den;
        a_mag = num_e[W-1] ? ('0 - num_e) : num_e;
        n_mag = r_n[FW-1] ? ('0 - r_n) : r_n;
        d_mag = r_d[FW-1] ? ('0 - r_d) : r_d;

        sum_t  = r_p1 + r_p2;
        diff_t = {1'b0, r_p1} - {1'b0, r_p2};
        if (r_a_neg == r_t2_neg) begin
            numc   = sum_t;
            sneg_c = r_a_neg;
        end else if (!diff_t[PW]) begin
            numc   = diff_t[PW-1:0];
            sneg_c = r_a_neg;
        end else begin
            numc   = r_p2 - r_p1;
            sneg_c = r_t2_neg;
        end

        a_gt   = r_ma > r_mb;
        big    = a_gt ? r_ma : r_mb;
        lesser = a_gt ? r_mb : r_ma;

        sh1 = {r_rem1, r_p1[PW-1]};
        sh2 = {r_rem2, r_p3[PW-1]};
        ge1 = sh1 >= {1'b0, r_ma};
        ge2 = sh2 >= {1'b0, r_ma};

        den_fit = r_p3[PW-1:W-1] == '0;
        num_fit = (r_p1[PW-1:W] == '0) &&
                  (!r_p1[W-1] || (r_s_neg && r_p1[W-2:0] == '0));

        out_busy = r_o_valid && i_out_stall;
    end

    always_comb begin
        n_n = r_n;  n_d = r_d;  n_restart = r_restart;
        n_acc_num = r_acc_num;  n_acc_den = r_acc_den;  n_acc_status = r_acc_status;
        n_ma = r_ma;  n_mb = r_mb;
        n_p1 = r_p1;  n_p2 = r_p2;  n_p3 = r_p3;
        n_rem1 = r_rem1;  n_rem2 = r_rem2;
        n_cnt = r_cnt;  n_k = r_k;
        n_a_neg = r_a_neg;  n_t2_neg = r_t2_neg;  n_s_neg = r_s_neg;
        n_o_valid = r_o_valid && i_out_stall;
        n_o_num = r_o_num;  n_o_den = r_o_den;  n_o_status = r_o_status;

        case (i_cw.uop)
            rsa_pkg::U_LOAD: begin
                if (i_in_valid) begin
                    n_n       = i_frac_num;
                    n_d       = i_frac_den;
                    n_restart = i_restart;
                end
            end
            rsa_pkg::U_PREP: begin
                n_acc_num    = num_e;
                n_acc_den    = den_e;
                n_acc_status = (st_e == rsa_pkg::ST_OK && r_d == '0) ?
                               rsa_pkg::ST_ZERO_DEN : st_e;
                n_ma     = PW'(a_mag);
                n_mb     = PW'(den_e);
                n_n      = n_mag;
                n_d      = d_mag;
                n_a_neg  = num_e[W-1];
                n_t2_neg = r_n[FW-1] ^ r_d[FW-1];
                n_p1     = '0;
                n_p2     = '0;
                n_p3     = '0;
                n_cnt    = CW'(FW - 1);
            end
            rsa_pkg::U_MUL: begin
                n_p1  = r_p1 + (r_d[0] ? r_ma : '0);
                n_p3  = r_p3 + (r_d[0] ? r_mb : '0);
                n_p2  = r_p2 + (r_n[0] ? r_mb : '0);
                n_ma  = {r_ma[PW-2:0], 1'b0};
                n_mb  = {r_mb[PW-2:0], 1'b0};
                n_d   = {1'b0, r_d[FW-1:1]};
                n_n   = {1'b0, r_n[FW-1:1]};
                n_cnt = r_cnt - CW'(1);
            end
            rsa_pkg::U_COMB: begin
                n_p1    = numc;
                n_s_neg = sneg_c;
                n_ma    = numc;
                n_mb    = r_p3;
                n_k     = '0;
            end
            rsa_pkg::U_G_TWO: begin
                if (!r_ma[0] && !r_mb[0]) begin
                    n_ma = {1'b0, r_ma[PW-1:1]};
                    n_mb = {1'b0, r_mb[PW-1:1]};
                    n_k  = r_k + CW'(1);
                end
            end
            rsa_pkg::U_G_AODD: begin
                if (!r_ma[0]) begin
                    n_ma = {1'b0, r_ma[PW-1:1]};
                end
            end
            rsa_pkg::U_G_BODD: begin
                if (!r_mb[0]) begin
                    n_mb = {1'b0, r_mb[PW-1:1]};
                end
            end
            rsa_pkg::U_G_SUB: begin
                n_ma = lesser;
                n_mb = big - lesser;
            end
            rsa_pkg::U_G_SCALE: begin
                if (r_k != '0) begin
                    n_ma = {r_ma[PW-2:0], 1'b0};
                    n_k  = r_k - CW'(1);
                end
            end
            rsa_pkg::U_DIV_INIT: begin
                n_rem1 = '0;
                n_rem2 = '0;
                n_cnt  = CW'(PW - 1);
            end
            rsa_pkg::U_DIV: begin
                n_rem1 = ge1 ? PW'(sh1 - {1'b0, r_ma}) : sh1[PW-1:0];
                n_rem2 = ge2 ? PW'(sh2 - {1'b0, r_ma}) : sh2[PW-1:0];
                n_p1   = {r_p1[PW-2:0], ge1};
                n_p3   = {r_p3[PW-2:0], ge2};
                n_cnt  = r_cnt - CW'(1);
            end
            rsa_pkg::U_CHECK: begin
                if (den_fit && num_fit) begin
                    n_acc_num = r_s_neg ? ('0 - r_p1[W-1:0]) : r_p1[W-1:0];
                    n_acc_den = r_p3[W-2:0];
                end else begin
                    n_acc_status = rsa_pkg::ST_OVERFLOW;
                end
            end
            rsa_pkg::U_ZERO: begin
                n_acc_num = '0;
                n_acc_den = (W-1)'(1);
            end
            rsa_pkg::U_OUT: begin
                if (!out_busy) begin
                    n_o_valid  = 1'b1;
                    n_o_num    = r_acc_num;
                    n_o_den    = r_acc_den;
                    n_o_status = r_acc_status;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_num    <= '0;
            r_acc_den    <= (W-1)'(1);
            r_acc_status <= rsa_pkg::ST_OK;
            r_o_valid    <= 1'b0;
        end else begin
            r_acc_num    <= n_acc_num;
            r_acc_den    <= n_acc_den;
            r_acc_status <= n_acc_status;
            r_o_valid    <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n        <= n_n;
        r_d        <= n_d;
        r_restart  <= n_restart;
        r_ma       <= n_ma;
        r_mb       <= n_mb;
        r_p1       <= n_p1;
        r_p2       <= n_p2;
        r_p3       <= n_p3;
        r_rem1     <= n_rem1;
        r_rem2     <= n_rem2;
        r_cnt      <= n_cnt;
        r_k        <= n_k;
        r_a_neg    <= n_a_neg;
        r_t2_neg   <= n_t2_neg;
        r_s_neg    <= n_s_neg;
        r_o_num    <= n_o_num;
        r_o_den    <= n_o_den;
        r_o_status <= n_o_status;
    end

    always_comb begin
        o_flags.in_valid  = i_in_valid;
        o_flags.skip      = (st_e != rsa_pkg::ST_OK) || (r_d == '0);
        o_flags.cnt_nz    = r_cnt != '0;
        o_flags.num_zero  = numc == '0;
        o_flags.both_even = !r_ma[0] && !r_mb[0];
        o_flags.a_even    = !r_ma[0];
        o_flags.b_even    = !r_mb[0];
        o_flags.a_ne_b    = r_ma != r_mb;
        o_flags.k_nz      = r_k != '0;
        o_flags.out_busy  = out_busy;
    end

    assign o_out_valid  = r_o_valid;
    assign o_sum_num    = r_o_num;
    assign o_sum_den    = r_o_den;
    assign o_sum_status = r_o_status;

    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acc_den != '0)
        else $error("running denominator is zero");

    a_gcd_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cw.uop == rsa_pkg::U_DIV_INIT |-> r_ma != '0)
        else $error("gcd is zero at divide start");

    a_exact_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cw.uop == rsa_pkg::U_CHECK |-> (r_rem1 == '0 && r_rem2 == '0))
        else $error("gcd does not divide the sum");

    a_frozen_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_acc_status != rsa_pkg::ST_OK && i_cw.uop != rsa_pkg::U_PREP)
        |=> ($stable(r_acc_num) && $stable(r_acc_den)))
        else $error("sum changed while status is sticky");

endmodule

// ----- rtl/rational_sum_accumulator_core.sv -----
// Top level of the rational sum accumulator: sequencer plus datapath.
//
// Input channel: i_in_valid / o_in_stall carry one word: i_frac_num, i_frac_den and
// i_restart. A word is taken at a clock edge with i_in_valid high and o_in_stall low.
// Output channel: o_out_valid / i_out_stall carry one result word per input word:
// the reduced running sum o_sum_num / o_sum_den and o_sum_status (0 ok, 1 zero
// denominator seen, 2 overflow). Error status is sticky until a word with restart.
// One word is worked on at a time under a microcoded sequencer. An accepted word runs
// through prep, the 32-step shift-add multiply, combine, the binary gcd loop (its
// length depends on the operands), the (VALUE_WIDTH+32)-step divider, the check and
// the output step; a zero sum skips gcd and divide, and a word that hits a sticky
// error or a zero denominator goes from prep straight to the output step. The next
// word is taken after the result is loaded, by way of a wrap step.
// A result waits in an output register; the next input word is taken while it
// waits, and the sequencer holds in its output step if the register is still full.
// Synchronous reset clears the sum to 0/1 with status ok and drops o_out_valid.
module rational_sum_accumulator_core #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [rsa_pkg::FRAC_W-1:0] i_frac_num,
    input  logic signed [rsa_pkg::FRAC_W-1:0] i_frac_den,
    input  logic                              i_restart,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [VALUE_WIDTH-1:0]     o_sum_num,
    output logic [VALUE_WIDTH-2:0]            o_sum_den,
    output logic [1:0]                        o_sum_status
);

    rsa_pkg::t_cw    cw;
    rsa_pkg::t_flags flags;

    rsa_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_cw    (cw)
    );

    rsa_dp #(
        .W (VALUE_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cw         (cw),
        .i_in_valid   (i_in_valid),
        .i_frac_num   (i_frac_num),
        .i_frac_den   (i_frac_den),
        .i_restart    (i_restart),
        .i_out_stall  (i_out_stall),
        .o_flags      (flags),
        .o_out_valid  (o_out_valid),
        .o_sum_num    (o_sum_num),
        .o_sum_den    (o_sum_den),
        .o_sum_status (o_sum_status)
    );

    assign o_in_stall = (cw.uop != rsa_pkg::U_LOAD);

endmodule
